// File: rtl/core/bffb_pkg.sv
// Shared types and constants for the bounded-friction residual block.
`timescale 1ns / 1ps
package bffb_pkg;

  // Sequencer states of the residual engine
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ROOT,
    ST_DIFF,
    ST_UPDATE
  } bffb_state_e;

  // Weight of a half-word partial product inside a full square
  typedef enum logic [1:0] {
    SH_LL,
    SH_HL,
    SH_HH
  } bffb_shift_e;

  // Six partial products (three per square), then a drain step
  localparam logic [2:0] MulDrain = 3'd6;

endpackage

// File: rtl/core/bffb_in_if.sv
// Input channel of the residual block: one vector element per transfer.
`timescale 1ns / 1ps
interface bffb_in_if #(
  parameter int unsigned DataWidth = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] friction_impulse;
  logic signed [DataWidth-1:0] relative_velocity;
  logic        [DataWidth-2:0] bound_limit;
  logic                        last_element;

  modport source (
    output valid, friction_impulse, relative_velocity, bound_limit, last_element,
    input  ready
  );
  modport sink (
    input  valid, friction_impulse, relative_velocity, bound_limit, last_element,
    output ready
  );
endinterface

// File: rtl/core/bffb_out_if.sv
// Output channel of the residual block: one norm per vector.
`timescale 1ns / 1ps
interface bffb_out_if #(
  parameter int unsigned DataWidth = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] residual_norm;

  modport source (
    output valid, residual_norm,
    input  ready
  );
  modport sink (
    input  valid, residual_norm,
    output ready
  );
endinterface

// File: rtl/core/bffb_isqrt.sv
// Iterative digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module bffb_isqrt #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2*DATA_WIDTH-1:0]   radicand_i,
  output logic                      done_o,
  output logic [DATA_WIDTH-1:0]     root_o
);
  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned RemW = W + 2;
  localparam int unsigned CmpW = W + 4;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [2*W-1:0]  rad_q, rad_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [W-1:0]    root_q, root_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [CmpW-1:0] rem_sh;
  logic [CmpW-1:0] trial;
  logic [CmpW-1:0] rem_sub;

  // Bring down the next bit pair and try the trial subtraction
  always_comb begin
    rem_sh  = {rem_q, rad_q[2*W-1 -: 2]};
    trial   = CmpW'({root_q, 2'b01});
    rem_sub = rem_sh - trial;
  end

  // Advance one digit per cycle while busy
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[2*W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sub[RemW-1:0];
        root_d = {root_q[W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RemW-1:0];
        root_d = {root_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Working registers of the root
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/core/bounded_friction_fb_residual.sv
// Top level: Fischer-Burmeister residual infinity norm over bounded friction.
// Elements are taken one at a time: the next is accepted only once the last has passed
// through every sequencer state; the root unit settles one bit per cycle and the shared
// half-width multiplier forms the partial products of both squares for each element.
// The next element is taken while a finished norm still waits on the output.
// Reset clears the sequencer, the output valid and the running maximum.
`timescale 1ns / 1ps
module bounded_friction_fb_residual #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bffb_in_if.sink   in_i,
  bffb_out_if.source out_o
);
  import bffb_pkg::*;

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned HalfW = (W + 1) / 2;
  localparam int unsigned ProdW = 2 * HalfW;
  localparam int unsigned AccW  = 2 * W;
  localparam int unsigned DiffW = W + 2;

  bffb_state_e state_q, state_d;

  logic signed [W-1:0] l_q, l_d;
  logic signed [W-1:0] y_q, y_d;
  logic                last_q;
  logic [W-1:0]        lmag_q, ymag_q;
  logic [2:0]          mul_cnt_q, mul_cnt_d;
  logic [ProdW-1:0]    prod_q;
  bffb_shift_e         sh_q, sh_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic signed [DiffW-1:0] diff_q;
  logic [W-1:0]        max_q, max_d;
  logic                out_valid_q, out_valid_d;
  logic [W-1:0]        out_norm_q;

  // Sequencer controls
  logic in_fire;
  logic prep_en;
  logic mul_issue;
  logic acc_en;
  logic sqrt_start;
  logic sqrt_done;
  logic diff_en;
  logic upd_fire;

  logic [W-1:0] root;

  // Project the velocity and form the violation
  logic signed [W:0] bx, cx, babs, yx;
  always_comb begin
    bx   = {in_i.friction_impulse[W-1], in_i.friction_impulse};
    cx   = $signed({2'b00, in_i.bound_limit});
    babs = bx[W] ? -bx : bx;
    yx   = cx - babs;
    y_d  = yx[W-1:0];
    if (cx == '0) begin
      l_d = '0;
    end else if (bx <= -cx) begin
      l_d = in_i.relative_velocity[W-1] ? in_i.relative_velocity : '0;
    end else if (bx >= cx) begin
      l_d = in_i.relative_velocity[W-1] ? '0 : in_i.relative_velocity;
    end else begin
      l_d = in_i.relative_velocity;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_PREP;
      ST_PREP:   state_d = ST_MUL;
      ST_MUL:    if (mul_cnt_q == MulDrain) state_d = ST_ROOT;
      ST_ROOT:   if (sqrt_done) state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    prep_en    = 1'b0;
    mul_issue  = 1'b0;
    acc_en     = 1'b0;
    sqrt_start = 1'b0;
    diff_en    = 1'b0;
    upd_fire   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_i.ready = 1'b1;
      ST_PREP:   prep_en = 1'b1;
      ST_MUL: begin
        mul_issue  = (mul_cnt_q != MulDrain);
        acc_en     = (mul_cnt_q != 3'd0);
        sqrt_start = (mul_cnt_q == MulDrain);
      end
      ST_ROOT:   ;
      ST_DIFF:   diff_en = 1'b1;
      ST_UPDATE: upd_fire = !last_q || !out_valid_q || out_o.ready;
      default:   ;
    endcase
  end

  assign in_fire = in_i.valid && in_i.ready;

  // Pick half-words of the magnitude being squared
  logic [W-1:0]     mag_sel;
  logic [HalfW-1:0] mag_hi, mag_lo, op_a, op_b;
  always_comb begin
    mag_sel = (mul_cnt_q < 3'd3) ? lmag_q : ymag_q;
    mag_hi  = HalfW'(mag_sel[W-1:HalfW]);
    mag_lo  = mag_sel[HalfW-1:0];
    op_a    = mag_lo;
    op_b    = mag_lo;
    sh_d    = SH_LL;
    case (mul_cnt_q) inside
      3'd0, 3'd3: begin
        op_a = mag_hi;
        op_b = mag_hi;
        sh_d = SH_HH;
      end
      3'd1, 3'd4: begin
        op_a = mag_hi;
        op_b = mag_lo;
        sh_d = SH_HL;
      end
      default: begin
        op_a = mag_lo;
        op_b = mag_lo;
        sh_d = SH_LL;
      end
    endcase
  end

  // Accumulate the weighted partial product
  logic [AccW-1:0] pp_x, pp_sh;
  always_comb begin
    pp_x = AccW'(prod_q);
    case (sh_q)
      SH_HH:   pp_sh = pp_x << ProdW;
      SH_HL:   pp_sh = pp_x << (HalfW + 1);
      default: pp_sh = pp_x;
    endcase
    acc_d = acc_q;
    if (prep_en) begin
      acc_d = '0;
    end else if (acc_en) begin
      acc_d = acc_q + pp_sh;
    end
  end

  assign mul_cnt_d = prep_en ? 3'd0 : (state_q == ST_MUL ? mul_cnt_q + 3'd1 : mul_cnt_q);

  bffb_isqrt #(
    .DATA_WIDTH (W)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_d),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Saturate the residual magnitude and fold it into the maximum
  logic [DiffW-1:0] diff_abs;
  logic [W-1:0]     fb;
  logic [W-1:0]     max_new;
  always_comb begin
    diff_abs = diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
    fb       = (diff_abs[DiffW-1:W] != '0) ? '1 : diff_abs[W-1:0];
    max_new  = (fb > max_q) ? fb : max_q;
    max_d    = max_q;
    if (upd_fire) begin
      max_d = last_q ? '0 : max_new;
    end
  end

  // Set on a finished vector, drop on an output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (upd_fire && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_cnt_q   <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_cnt_q   <= mul_cnt_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      l_q    <= l_d;
      y_q    <= y_d;
      last_q <= in_i.last_element;
    end
    if (prep_en) begin
      lmag_q <= l_q[W-1] ? W'(-l_q) : W'(l_q);
      ymag_q <= y_q[W-1] ? W'(-y_q) : W'(y_q);
    end
    if (mul_issue) begin
      prod_q <= ProdW'(op_a) * ProdW'(op_b);
      sh_q   <= sh_d;
    end
    acc_q <= acc_d;
    if (diff_en) begin
      diff_q <= $signed(DiffW'(root)) - DiffW'(l_q) - DiffW'(y_q);
    end
    if (upd_fire && last_q) begin
      out_norm_q <= max_new;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.residual_norm = out_norm_q;

endmodule

// File: dv/bffb_norm_checker.sv
// Watches both channels of the residual block, predicts every norm and compares it.
`timescale 1ns / 1ps
module bffb_norm_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  bffb_in_if   elem_i,
  bffb_out_if  norm_i,
  output int   fail_count_o,
  output int   norms_due_o
);

  localparam logic [63:0] NormCeiling = (64'd1 << DATA_WIDTH) - 64'd1;

  logic [DATA_WIDTH-1:0] expected_norms[$];
  logic [63:0]           vector_peak;
  int                    fails = 0;

  // Residual of one element, saturated to the norm width
  function automatic logic [63:0] element_residual(
    input logic signed [DATA_WIDTH-1:0] impulse,
    input logic signed [DATA_WIDTH-1:0] velocity,
    input logic        [DATA_WIDTH-2:0] bound
  );
    longint      imp, vel, bnd, proj, slack, gap;
    logic [127:0] proj_mag, slack_mag, sum_sq, cand;
    logic [63:0]  root, gap_mag;
    imp = impulse;
    vel = velocity;
    bnd = longint'(bound);

    // Project the velocity onto the side the impulse sits on
    proj = vel;
    if (bnd == 0) begin
      proj = 0;
    end else if (imp <= -bnd) begin
      proj = (vel < 0) ? vel : 0;
    end else if (imp >= bnd) begin
      proj = (vel > 0) ? vel : 0;
    end
    slack = bnd - ((imp < 0) ? -imp : imp);

    proj_mag  = (proj < 0) ? -proj : proj;
    slack_mag = (slack < 0) ? -slack : slack;
    sum_sq    = proj_mag * proj_mag + slack_mag * slack_mag;

    // Largest root whose square does not exceed the sum
    root = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      cand = {64'd0, root | (64'd1 << k)};
      if (cand * cand <= sum_sq) root = cand[63:0];
    end

    gap     = longint'(root) - proj - slack;
    gap_mag = (gap < 0) ? -gap : gap;
    return (gap_mag > NormCeiling) ? NormCeiling : gap_mag;
  endfunction

  // Compare finished norms, then fold accepted elements into the vector peak
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0]           res;
    logic [DATA_WIDTH-1:0] want;
    if (!rst_ni) begin
      expected_norms.delete();
      vector_peak  = 64'd0;
      fail_count_o <= 0;
      norms_due_o  <= 0;
    end else begin
      if (norm_i.valid && norm_i.ready) begin
        if (expected_norms.size() == 0) begin
          $display("%0t ns: norm %h arrived with none expected", $time, norm_i.residual_norm);
          fails++;
        end else begin
          want = expected_norms.pop_front();
          if (norm_i.residual_norm !== want) begin
            $display("%0t ns: residual_norm expected %h actual %h",
                     $time, want, norm_i.residual_norm);
            fails++;
          end
        end
      end
      if (elem_i.valid && elem_i.ready) begin
        res = element_residual(elem_i.friction_impulse, elem_i.relative_velocity,
                               elem_i.bound_limit);
        if (res > vector_peak) vector_peak = res;
        if (elem_i.last_element) begin
          expected_norms.push_back(vector_peak[DATA_WIDTH-1:0]);
          vector_peak = 64'd0;
        end
      end
      fail_count_o <= fails;
      norms_due_o  <= expected_norms.size();
    end
  end

endmodule

// File: dv/bounded_friction_fb_residual_tb.sv
// Stimulus, handshake pacing and verdict for the bounded-friction residual block.
`timescale 1ns / 1ps
module bounded_friction_fb_residual_tb;

  localparam int unsigned DW          = 32;
  localparam int          RandItems   = 930;
  localparam int          DrainCycles = DW + 20;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   norms_due;
  int   feed_gap_pct;
  int   drain_stall_pct;

  bffb_in_if  #(.DataWidth(DW)) elem_if ();
  bffb_out_if #(.DataWidth(DW)) norm_if ();

  bounded_friction_fb_residual #(.DATA_WIDTH(DW)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (elem_if),
    .out_o  (norm_if)
  );

  bffb_norm_checker #(.DATA_WIDTH(DW)) norm_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_i       (elem_if),
    .norm_i       (norm_if),
    .fail_count_o (mismatches),
    .norms_due_o  (norms_due)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the norm output at random
  always @(posedge clk_i) begin
    norm_if.ready <= ($urandom_range(99) >= drain_stall_pct);
  end

  // Present one element, after idling at random, and hold it until the transfer
  task automatic send_element(
    input logic [DW-1:0] imp,
    input logic [DW-1:0] vel,
    input logic [DW-2:0] bnd,
    input logic          last
  );
    while ($urandom_range(99) < feed_gap_pct) begin
      elem_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    elem_if.valid             <= 1'b1;
    elem_if.friction_impulse  <= imp;
    elem_if.relative_velocity <= vel;
    elem_if.bound_limit       <= bnd;
    elem_if.last_element      <= last;
    do @(posedge clk_i); while (!elem_if.ready);
  endtask

  // Draw an element biased toward the projection boundaries
  task automatic send_random_element(input logic last);
    longint bnd, imp, vel;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 10) bnd = 0;
    else if (pick < 35) bnd = $urandom_range(32'h0003_FFFF);
    else if (pick < 45) bnd = 64'h7FFF_FFFF - $urandom_range(255);
    else bnd = $urandom & 32'h7FFF_FFFF;

    pick = $urandom_range(99);
    if (pick < 20) imp = bnd;
    else if (pick < 40) imp = -bnd;
    else if (pick < 65) imp = (bnd == 0) ? 0 : longint'($urandom) % (2 * bnd - 1) - (bnd - 1);
    else imp = longint'($signed($urandom));

    pick = $urandom_range(99);
    if (pick < 45) vel = longint'($signed($urandom));
    else if (pick < 75) vel = longint'($urandom_range(32'h0008_0000)) - 64'sh4_0000;
    else if (pick < 85) vel = $urandom_range(1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
    else vel = 0;

    send_element(imp[DW-1:0], vel[DW-1:0], bnd[DW-2:0], last);
  endtask

  // Stop feeding until every outstanding norm has come out
  task automatic hold_until_drained();
    elem_if.valid <= 1'b0;
    do @(posedge clk_i); while (norms_due != 0);
  endtask

  initial begin
    int sent;
    int vec_len;
    int phase;
    rst_ni                    = 1'b0;
    elem_if.valid             = 1'b0;
    elem_if.friction_impulse  = '0;
    elem_if.relative_velocity = '0;
    elem_if.bound_limit       = '0;
    elem_if.last_element      = 1'b0;
    norm_if.ready             = 1'b0;
    feed_gap_pct              = 38;
    drain_stall_pct           = 87;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero vector of one element
    send_element(32'h0000_0000, 32'h0000_0000, 31'h0000_0000, 1'b1);
    // Zero bound forces a zero projection; the most negative impulse saturates the norm
    send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0000_0000, 1'b0);
    send_element(32'h8000_0000, 32'h8000_0000, 31'h0000_0000, 1'b1);
    send_element(32'h8000_0000, 32'h8000_0000, 31'h0000_0001, 1'b1);
    // Impulse at minus the bound: velocity clamped to at most zero
    send_element(32'hFFFF_0000, 32'h0003_0000, 31'h0001_0000, 1'b0);
    send_element(32'hFFFF_0000, 32'hFFFF_8000, 31'h0001_0000, 1'b0);
    // Impulse at the bound: velocity clamped to at least zero
    send_element(32'h0001_0000, 32'hFFFE_0000, 31'h0001_0000, 1'b0);
    send_element(32'h0001_0000, 32'h7FFF_FFFF, 31'h0001_0000, 1'b1);
    // Impulse strictly inside the bound: velocity passes through
    send_element(32'h0000_8000, 32'h8000_0000, 31'h0001_0000, 1'b0);
    send_element(32'h0000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_element(32'h0000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
    // Largest bound with impulses at both extremes, then a unit bound
    send_element(32'h7FFF_FFFF, 32'h0000_0001, 31'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_element(32'hFFFF_FFFF, 32'h0001_2345, 31'h0000_0001, 1'b1);
    // Negative violation with a huge impulse
    send_element(32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_0001, 1'b1);
    // Root that truncates
    send_element(32'h0000_0001, 32'h0000_FFFF, 31'h0000_0003, 1'b1);
    // Short vector whose peak sits on its last element
    send_element(32'h0004_0000, 32'h0001_0000, 31'h0005_0000, 1'b0);
    send_element(32'hFFF9_0000, 32'h0002_0000, 31'h0001_8000, 1'b0);
    send_element(32'h0000_0001, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);

    hold_until_drained();

    // Random vectors across three pacing phases
    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      if (phase == 0 && sent >= RandItems / 3) begin
        phase           = 1;
        feed_gap_pct    = 87;
        drain_stall_pct = 38;
      end
      if (phase == 1 && sent >= 2 * RandItems / 3) begin
        phase           = 2;
        feed_gap_pct    = 0;
        drain_stall_pct = 0;
      end
      vec_len = ($urandom_range(4) == 0) ? 1 : $urandom_range(8, 2);
      for (int k = 0; k < vec_len; k++) begin
        send_random_element(k == vec_len - 1);
      end
      sent += vec_len;
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
